// ===== rtl/bdq_pkg.sv =====
// ----------------------------------------------------------------------------
// bdq_pkg: shared types and codes for the bounded deque
// Word formats of both channels, operation and status codes, cell commands.
// ----------------------------------------------------------------------------
package bdq_pkg;

    localparam int DATA_W = 32;

    typedef logic signed [DATA_W-1:0] data_t;

    // Operation codes
    localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [2:0] OP_POP_FRONT  = 3'd2;
    localparam logic [2:0] OP_POP_BACK   = 3'd3;
    localparam logic [2:0] OP_DUMP       = 3'd4;

    // Status codes
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;

    typedef struct packed {
        logic [2:0] operation;
        data_t      value;
    } req_word_t;

    typedef struct packed {
        logic [1:0] status;
        data_t      value_res;
        logic       last;
    } rsp_word_t;

    // Command broadcast to every cell
    typedef enum logic [2:0] {
        CELL_HOLD       = 3'd0,
        CELL_SHIFT_UP   = 3'd1,
        CELL_SHIFT_DOWN = 3'd2,
        CELL_WRITE_TAIL = 3'd3,
        CELL_ROTATE     = 3'd4
    } cell_cmd_t;

    // Per-cell control: shared command plus the cell's position versus count
    typedef struct packed {
        cell_cmd_t cmd;
        logic      at_tail;   // index == count
        logic      at_last;   // index == count - 1
        logic      active;    // index <  count
    } cell_ctl_t;

endpackage

// ===== rtl/bdq_cell.sv =====
// ----------------------------------------------------------------------------
// bdq_cell: one storage place of the deque chain
// Holds one word and loads from its lower or upper neighbor, the input word
// or the wrap bus, as the broadcast command and its position select.
// ----------------------------------------------------------------------------
module bdq_cell (
    input  logic               clk,
    input  bdq_pkg::cell_ctl_t ctl,
    input  bdq_pkg::data_t     word,    // pushed word
    input  bdq_pkg::data_t     lower,   // neighbor toward the front
    input  bdq_pkg::data_t     upper,   // neighbor toward the back
    input  bdq_pkg::data_t     wrap,    // front entry, recirculated on dump
    output bdq_pkg::data_t     q
);

    bdq_pkg::data_t data_reg;
    bdq_pkg::data_t data_next;

    // Next value select
    always_comb
    begin
        unique case (ctl.cmd)
            bdq_pkg::CELL_HOLD:       data_next = data_reg;
            bdq_pkg::CELL_SHIFT_UP:   data_next = lower;
            bdq_pkg::CELL_SHIFT_DOWN: data_next = upper;
            bdq_pkg::CELL_WRITE_TAIL: data_next = ctl.at_tail ? word : data_reg;
            bdq_pkg::CELL_ROTATE:
            begin
                if (ctl.at_last)
                    data_next = wrap;
                else if (ctl.active)
                    data_next = upper;
                else
                    data_next = data_reg;
            end
            default:                  data_next = data_reg;
        endcase
    end

    // Storage, no reset: places are written before they are read
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign q = data_reg;

endmodule

// ===== rtl/bounded_deque_shift_array.sv =====
// ----------------------------------------------------------------------------
// bounded_deque_shift_array: bounded double-ended queue in a shifting chain
// A row of CAPACITY cells holds the entries front first; a count register
// tracks occupancy and a small sequencer streams entries on dump.
//
//   channel | handshake           | word
//   --------+---------------------+----------------------------------------
//   req     | req_valid/req_ready | operation, value
//   rsp     | rsp_valid/rsp_ready | status, value_res, last
//
// Push and pop give their result in the cycle after they are taken.
// Dump of n entries streams one entry per cycle, while rsp is not stalled,
// through a rotation of the chain; req stays blocked until it has finished.
// Reset empties the deque at once; no clearing pass.
// A stalled rsp word blocks req and freezes the dump stream.
// ----------------------------------------------------------------------------
module bounded_deque_shift_array #(
    parameter int CAPACITY = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  bdq_pkg::req_word_t req,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output bdq_pkg::rsp_word_t rsp
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_DUMP = 2'b10
    } state_t;

    state_t             state_reg,  state_next;
    logic [CNT_W-1:0]   count_reg,  count_next;
    logic [CNT_W-1:0]   remain_reg, remain_next;
    logic               rsp_valid_reg, rsp_valid_next;
    bdq_pkg::rsp_word_t rsp_reg,    rsp_next;

    bdq_pkg::cell_cmd_t cmd;
    bdq_pkg::data_t     q [CAPACITY];
    logic               slot_free;
    logic               accept;
    logic               is_full;
    logic               is_empty;

    assign slot_free = !rsp_valid_reg || rsp_ready;
    assign req_ready = (state_reg == S_IDLE) && slot_free;
    assign accept    = req_valid && req_ready;
    assign is_full   = (count_reg == CNT_W'(CAPACITY));
    assign is_empty  = (count_reg == '0);

    // Sequencer: decode operations, drive the chain, build result words
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        remain_next    = remain_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_next       = rsp_reg;
        cmd            = bdq_pkg::CELL_HOLD;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (req.operation)
                        bdq_pkg::OP_PUSH_FRONT,
                        bdq_pkg::OP_PUSH_BACK:
                        begin
                            rsp_valid_next = 1'b1;
                            rsp_next       = '{bdq_pkg::STAT_FULL, '0, 1'b1};
                            if (!is_full)
                            begin
                                rsp_next.status = bdq_pkg::STAT_OK;
                                count_next      = count_reg + 1'b1;
                                cmd = (req.operation == bdq_pkg::OP_PUSH_FRONT) ?
                                      bdq_pkg::CELL_SHIFT_UP : bdq_pkg::CELL_WRITE_TAIL;
                            end
                        end
                        bdq_pkg::OP_POP_FRONT,
                        bdq_pkg::OP_POP_BACK:
                        begin
                            rsp_valid_next = 1'b1;
                            rsp_next       = '{bdq_pkg::STAT_EMPTY, '0, 1'b1};
                            if (!is_empty)
                            begin
                                rsp_next.status = bdq_pkg::STAT_OK;
                                count_next      = count_reg - 1'b1;
                                cmd = (req.operation == bdq_pkg::OP_POP_FRONT) ?
                                      bdq_pkg::CELL_SHIFT_DOWN : bdq_pkg::CELL_HOLD;
                            end
                        end
                        bdq_pkg::OP_DUMP:
                        begin
                            if (is_empty)
                            begin
                                rsp_valid_next = 1'b1;
                                rsp_next       = '{bdq_pkg::STAT_EMPTY, '0, 1'b1};
                            end
                            else
                            begin
                                remain_next = count_reg;
                                state_next  = S_DUMP;
                            end
                        end
                        default: ;  // unused codes: no result
                    endcase
                end
            end
            S_DUMP:
            begin
                // emit front entry and rotate it to the back of the used part
                if (slot_free)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_next       = '{bdq_pkg::STAT_OK, q[0], (remain_reg == CNT_W'(1))};
                    cmd            = bdq_pkg::CELL_ROTATE;
                    remain_next    = remain_reg - 1'b1;
                    if (remain_reg == CNT_W'(1))
                        state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            remain_reg    <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            remain_reg    <= remain_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Result word register
    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Cell chain, front at index 0
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        bdq_pkg::cell_ctl_t ctl;
        bdq_pkg::data_t     lower;
        bdq_pkg::data_t     upper;

        assign ctl.cmd     = cmd;
        assign ctl.at_tail = (count_reg == CNT_W'(i));
        assign ctl.at_last = (count_reg == CNT_W'(i + 1));
        assign ctl.active  = (CNT_W'(i) < count_reg);

        if (i == 0)
        begin : g_front
            assign lower = req.value;
        end
        else
        begin : g_mid_lo
            assign lower = q[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_back
            assign upper = q[i];
        end
        else
        begin : g_mid_hi
            assign upper = q[i+1];
        end

        bdq_cell u_cell (
            .clk   (clk),
            .ctl   (ctl),
            .word  (req.value),
            .lower (lower),
            .upper (upper),
            .wrap  (q[0]),
            .q     (q[i])
        );
    end

endmodule

// ===== rtl/bdq_checker.sv =====
// ----------------------------------------------------------------------------
// bdq_checker: port-level checks for the bounded deque
// Watches both channels and flags ordering and handshake slips.
// ----------------------------------------------------------------------------
module bdq_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               req_valid,
    input logic               req_ready,
    input bdq_pkg::req_word_t req,
    input logic               rsp_valid,
    input logic               rsp_ready,
    input bdq_pkg::rsp_word_t rsp
);

    // A stalled result word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("rsp word changed while stalled");

    // No new request is taken while a result is stuck
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |-> !req_ready)
        else $error("req taken over a stalled rsp word");

    // Push or pop gives its single result in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready &&
        (req.operation == bdq_pkg::OP_PUSH_FRONT || req.operation == bdq_pkg::OP_PUSH_BACK ||
         req.operation == bdq_pkg::OP_POP_FRONT  || req.operation == bdq_pkg::OP_POP_BACK)
        |=> rsp_valid && rsp.last && rsp.value_res == '0)
        else $error("push/pop result missing or malformed");

    // A non-final dump word is ok and keeps req blocked while it is shown
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.last
        |-> rsp.status == bdq_pkg::STAT_OK && !req_ready)
        else $error("dump stream broken");

    // Status code is always a defined one
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp.status == bdq_pkg::STAT_OK || rsp.status == bdq_pkg::STAT_FULL ||
                      rsp.status == bdq_pkg::STAT_EMPTY)
        else $error("undefined status code");

endmodule

bind bounded_deque_shift_array bdq_checker u_bdq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);

// ===== tb/sv/bounded_deque_shift_array_tb.sv =====
// ----------------------------------------------------------------------------
// bounded_deque_shift_array_tb: self-checking bench for the bounded deque
// A directed opening covers empty and full refusals, value extremes, dumps
// and unused codes. Biased random traffic follows, which alternately fills
// and drains the list. Both sides stall at random, and the receiver also
// holds off for one long stretch. A shadow list in a small scoreboard class
// predicts every response word, and each accepted word is checked field by
// field.
// ----------------------------------------------------------------------------
module bounded_deque_shift_array_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEQUE_SIZE = 8;

    // Shadow copy of the list plus the queue of response words still owed
    class deque_scoreboard #(int SIZE = 8);
        bdq_pkg::data_t     stored [SIZE];
        int                 depth;
        bdq_pkg::rsp_word_t awaited [$];
        int                 errors;

        function new();
            depth  = 0;
            errors = 0;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        function void await_word(logic [1:0] status, bdq_pkg::data_t val, logic last);
            bdq_pkg::rsp_word_t w;
            w.status    = status;
            w.value_res = val;
            w.last      = last;
            awaited.push_back(w);
        endfunction

        // Apply one accepted request to the shadow list
        function void note_request(bdq_pkg::req_word_t w);
            int i;
            case (w.operation)
                bdq_pkg::OP_PUSH_FRONT, bdq_pkg::OP_PUSH_BACK:
                    if (depth == SIZE)
                        await_word(bdq_pkg::STAT_FULL, '0, 1'b1);
                    else
                    begin
                        if (w.operation == bdq_pkg::OP_PUSH_FRONT)
                        begin
                            for (i = depth; i > 0; i--)
                                stored[i] = stored[i-1];
                            stored[0] = w.value;
                        end
                        else
                            stored[depth] = w.value;
                        depth++;
                        await_word(bdq_pkg::STAT_OK, '0, 1'b1);
                    end
                bdq_pkg::OP_POP_FRONT, bdq_pkg::OP_POP_BACK:
                    if (depth == 0)
                        await_word(bdq_pkg::STAT_EMPTY, '0, 1'b1);
                    else
                    begin
                        // pop at back only drops the count
                        if (w.operation == bdq_pkg::OP_POP_FRONT)
                            for (i = 0; i < depth - 1; i++)
                                stored[i] = stored[i+1];
                        depth--;
                        await_word(bdq_pkg::STAT_OK, '0, 1'b1);
                    end
                bdq_pkg::OP_DUMP:
                    if (depth == 0)
                        await_word(bdq_pkg::STAT_EMPTY, '0, 1'b1);
                    else
                        for (i = 0; i < depth; i++)
                            await_word(bdq_pkg::STAT_OK, stored[i], i == depth - 1);
                default: ;  // unused codes: no response, no change
            endcase
        endfunction

        task report_mismatch(string msg);
            $display("MISMATCH at %0t ns: %s", $time, msg);
            errors++;
        endtask

        task check_response(bdq_pkg::rsp_word_t got);
            bdq_pkg::rsp_word_t want;
            if (awaited.size() == 0)
            begin
                report_mismatch($sformatf("unexpected word status=%0d value=%0d last=%0d",
                                          got.status, got.value_res, got.last));
                return;
            end
            want = awaited.pop_front();
            if (got.status !== want.status)
                report_mismatch($sformatf("status %0d, expected %0d",
                                          got.status, want.status));
            if (got.value_res !== want.value_res)
                report_mismatch($sformatf("value_res %0d, expected %0d",
                                          got.value_res, want.value_res));
            if (got.last !== want.last)
                report_mismatch($sformatf("last %0d, expected %0d", got.last, want.last));
        endtask
    endclass

    logic               clk = 1'b0;
    logic               rst_n;
    logic               req_valid;
    logic               req_ready;
    bdq_pkg::req_word_t req;
    logic               rsp_valid;
    logic               rsp_ready;
    bdq_pkg::rsp_word_t rsp;

    deque_scoreboard #(DEQUE_SIZE) sb;

    bit calm;           // no idling on either side
    bit grow;           // random traffic leans toward pushes
    int rsp_hold_len;   // long receiver hold-off, picked up by the receiver
    int counted;        // random words sent that the block acts on

    bounded_deque_shift_array #(
        .CAPACITY (DEQUE_SIZE)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Offer one word and hold it until the block takes it
    task automatic send_word(input logic [2:0] op, input bdq_pkg::data_t val);
        bdq_pkg::req_word_t w;
        w.operation = op;
        w.value     = val;
        req       <= w;
        req_valid <= 1'b1;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
    endtask

    // Let the monitor note the last word, then wait for every owed response
    task automatic wait_drained();
        req_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // Biased random traffic; direction of the bias flips every 24 words the block acts on
    task automatic run_random(input int n);
        int             done;
        int             r;
        logic [2:0]     op;
        bdq_pkg::data_t val;
        done = 0;
        while (done < n)
        begin
            r = $urandom_range(0, 99);
            if (r < 4)
                op = 3'($urandom_range(5, 7));
            else if (r < 16)
                op = bdq_pkg::OP_DUMP;
            else if ($urandom_range(0, 99) < (grow ? 70 : 30))
                op = $urandom_range(0, 1) ? bdq_pkg::OP_PUSH_FRONT : bdq_pkg::OP_PUSH_BACK;
            else
                op = $urandom_range(0, 1) ? bdq_pkg::OP_POP_FRONT : bdq_pkg::OP_POP_BACK;

            case ($urandom_range(0, 7))
                0:       val = 32'sh7FFF_FFFF;
                1:       val = 32'sh8000_0000;
                2:       val = '0;
                3:       val = -32'sd1;
                default: val = bdq_pkg::data_t'($urandom);
            endcase

            if (!calm && $urandom_range(0, 4) == 0)
            begin
                req_valid <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge clk);
            end
            send_word(op, val);

            if (op <= bdq_pkg::OP_DUMP)
            begin
                done++;
                counted++;
                if (counted % 24 == 0)
                    grow = !grow;
            end
        end
    endtask

    // Receiver: random short stalls, one long hold-off on request
    initial
    begin : receiver
        rsp_ready <= 1'b0;
        @(posedge clk);
        while (rst_n !== 1'b1)
            @(posedge clk);
        forever
        begin
            if (rsp_hold_len > 0)
            begin
                rsp_ready <= 1'b0;
                repeat (rsp_hold_len) @(posedge clk);
                rsp_hold_len = 0;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                rsp_ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge clk);
            end
            else
            begin
                rsp_ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // Watch both channels
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && req_valid && req_ready)
            sb.note_request(req);
        if (rst_n === 1'b1 && rsp_valid === 1'b1 && rsp_ready)
            sb.check_response(rsp);
    end

    initial
    begin : stimulus
        int k;
        sb           = new();
        calm         = 1'b0;
        grow         = 1'b1;
        rsp_hold_len = 0;
        counted      = 0;
        req_valid <= 1'b0;
        req       <= '0;
        rst_n     <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: refusals on empty, extremes, dumps, unused codes, full list
        send_word(bdq_pkg::OP_DUMP,       '0);
        send_word(bdq_pkg::OP_POP_FRONT,  '0);
        send_word(bdq_pkg::OP_POP_BACK,   '0);
        send_word(bdq_pkg::OP_PUSH_FRONT, 32'sh7FFF_FFFF);
        send_word(bdq_pkg::OP_PUSH_BACK,  32'sh8000_0000);
        send_word(bdq_pkg::OP_PUSH_FRONT, '0);
        send_word(bdq_pkg::OP_PUSH_BACK,  -32'sd1);
        send_word(bdq_pkg::OP_DUMP,       '0);
        send_word(3'd5,                   32'sh1234_5678);
        send_word(bdq_pkg::OP_PUSH_BACK,  32'sh5555_5555);
        send_word(bdq_pkg::OP_PUSH_FRONT, 32'shAAAA_AAAA);
        send_word(bdq_pkg::OP_PUSH_BACK,  32'sh0F0F_0F0F);
        send_word(bdq_pkg::OP_PUSH_FRONT, 32'shF0F0_F0F0);
        send_word(bdq_pkg::OP_PUSH_FRONT, 32'sh0000_0001);
        send_word(bdq_pkg::OP_PUSH_BACK,  32'sh0000_0002);
        send_word(bdq_pkg::OP_DUMP,       '0);
        send_word(3'd6,                   '0);
        send_word(3'd7,                   -32'sd1);
        send_word(bdq_pkg::OP_POP_FRONT,  '0);
        send_word(bdq_pkg::OP_POP_BACK,   '0);
        send_word(bdq_pkg::OP_PUSH_BACK,  32'sh7654_3210);
        send_word(bdq_pkg::OP_DUMP,       '0);
        send_word(bdq_pkg::OP_POP_FRONT,  '0);
        send_word(bdq_pkg::OP_POP_BACK,   '0);
        send_word(bdq_pkg::OP_DUMP,       '0);

        run_random(80);

        // Receiver holds off while pushes and dumps keep coming
        rsp_hold_len = 48;
        for (k = 0; k < 20; k++)
            send_word(k % 5 == 4 ? bdq_pkg::OP_DUMP :
                      (k % 2 ? bdq_pkg::OP_PUSH_BACK : bdq_pkg::OP_PUSH_FRONT),
                      bdq_pkg::data_t'($urandom));

        run_random(80);

        // Sender pauses until every owed response has come back
        wait_drained();
        run_random(60);

        calm = 1'b1;
        run_random(50);

        wait_drained();
        repeat (20) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin : watchdog
        #400us;
        $display("Test completed with failures");
        $finish;
    end

endmodule
